/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted
`define ADGR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("adgr assertion failed");

// Check a property on every rising edge, reset included
`define ADGR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("adgr assertion failed");

`endif

/* src/adgr_pkg.sv */
// ---------------------------------------------------------------------------
// adgr_pkg
// Widths, constants and side-band types of the AdaGrad update pipeline.
// ---------------------------------------------------------------------------
package adgr_pkg;

    localparam int W_W      = 32;  // weight and gradient, signed Q7.24
    localparam int H_W      = 48;  // history, unsigned Q16.32
    localparam int LR_W     = 24;  // learning rate, unsigned Q0.24
    localparam int NUM_W    = 56;  // learning rate times gradient magnitude
    localparam int RAD_W    = 64;  // square root operand
    localparam int ROOT_W   = RAD_W / 2;
    localparam int SQ_STAGES = ROOT_W;
    localparam int DVS_W    = ROOT_W + 1;      // divisor is twice the root
    localparam int QUO_W    = 48;              // quotient bits produced
    localparam int DIV_STAGES = QUO_W;

    localparam logic [LR_W-1:0] LR_RESET = 24'd1677722;
    localparam logic [H_W-1:0]  H_MAX    = {H_W{1'b1}};

    // Side band carried alongside the square root
    typedef struct packed {
        logic [W_W-1:0]   weight;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [H_W-1:0]   hist;
        logic             hsat;
    } t_sqrt_side;

    // Side band carried alongside the divider
    typedef struct packed {
        logic [W_W-1:0] weight;
        logic           neg;
        logic [H_W-1:0] hist;
        logic           hsat;
    } t_div_side;

endpackage

/* src/adagrad_weight_update.sv */
// ---------------------------------------------------------------------------
// adagrad_weight_update
// AdaGrad element update: history plus squared gradient, then the weight
// steps against the gradient scaled by learn_rate / sqrt(history + eps).
// ---------------------------------------------------------------------------
// One element enters per cycle unless the output stalls. The path runs
// through the 32-stage square root and the 48-stage divider, one result bit
// per stage each; five front stages (input, magnitude, multipliers,
// rounding, history add), one stage forming dividend and divisor and the
// output register make up the rest. A stall on the output freezes the whole
// pipeline; it flows again as soon as the result is taken. Write the
// learning rate only while no element is in flight.
// ---------------------------------------------------------------------------
module adagrad_weight_update import adgr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LR_W-1:0]        i_cfg_learn_rate,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [W_W-1:0]  i_weight_in,
    input  logic signed [W_W-1:0]  i_grad_in,
    input  logic [H_W-1:0]         i_hist_in,
    // output channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [W_W-1:0]  o_weight_out,
    output logic [H_W-1:0]         o_hist_out,
    output logic                   o_sat_flag
);

    localparam int WIDE_W = QUO_W + 2;
    localparam logic signed [WIDE_W-1:0] W_HI = WIDE_W'(2147483647);
    localparam logic signed [WIDE_W-1:0] W_LO = -WIDE_W'(64'sd2147483648);

    logic [LR_W-1:0] r_lr;
    logic            adv;

    // front stage registers
    logic             r_s0_vld, r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s6_vld;
    logic [W_W-1:0]   r_s0_w, r_s1_w, r_s2_w, r_s3_w, r_s4_w;
    logic [W_W-1:0]   r_s0_g, r_s1_gmag;
    logic [H_W-1:0]   r_s0_h, r_s1_h, r_s2_h, r_s3_h, r_s4_h;
    logic             r_s1_neg, r_s2_neg, r_s3_neg, r_s4_neg;
    logic [63:0]      r_s2_sq;
    logic [NUM_W-1:0] r_s2_num, r_s3_num, r_s4_num;
    logic [H_W-1:0]   r_s3_sq32;
    logic             r_s4_hsat;
    logic [NUM_W-1:0] r_s6_dvd;
    logic [DVS_W-1:0] r_s6_dvs;
    t_div_side        r_s6_side;

    // output register
    logic             r_out_vld;
    logic [W_W-1:0]   r_out_w;
    logic [H_W-1:0]   r_out_h;
    logic             r_out_sat;

    logic [W_W-1:0]    n_s1_gmag;
    logic [63:0]       n_s3_rnd;
    logic [H_W:0]      n_s4_sum;
    logic [H_W:0]      hist_eps;
    logic [RAD_W-1:0]  sq_rad;
    t_sqrt_side        sq_side_in, sq_side_out;
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_div_side         dv_side_in;
    logic              dv_vld;
    logic [QUO_W-1:0]  dv_quo;
    t_div_side         dv_side;
    logic signed [WIDE_W-1:0] w_ext, m_ext, w_wide;
    logic [W_W-1:0]    n_out_w;
    logic              n_out_wsat;

    // Pipeline moves whenever the output register is free or being drained
    assign adv         = !(r_out_vld && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    // Hold the learning rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lr <= i_cfg_learn_rate;
        end
    end

    // Front stage logic
    assign n_s1_gmag = r_s0_g[W_W-1] ? W_W'(-r_s0_g) : r_s0_g;
    assign n_s3_rnd  = r_s2_sq + 64'd32768;
    assign n_s4_sum  = {1'b0, r_s3_h} + {1'b0, r_s3_sq32};
    assign hist_eps  = {1'b0, r_s4_h} + {{H_W{1'b0}}, 1'b1};
    assign sq_rad    = {1'b0, hist_eps, 14'b0};

    // Advance front valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else if (adv) begin
            r_s0_vld <= i_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s6_vld <= sq_vld;
        end
    end

    // Advance front payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_w    <= i_weight_in;
            r_s0_g    <= i_grad_in;
            r_s0_h    <= i_hist_in;
            // gradient magnitude and sign
            r_s1_w    <= r_s0_w;
            r_s1_h    <= r_s0_h;
            r_s1_neg  <= r_s0_g[W_W-1];
            r_s1_gmag <= n_s1_gmag;
            // square and scaled gradient
            r_s2_w    <= r_s1_w;
            r_s2_h    <= r_s1_h;
            r_s2_neg  <= r_s1_neg;
            r_s2_sq   <= r_s1_gmag * r_s1_gmag;
            r_s2_num  <= r_lr * r_s1_gmag;
            // round the square to Q16.32
            r_s3_w    <= r_s2_w;
            r_s3_h    <= r_s2_h;
            r_s3_neg  <= r_s2_neg;
            r_s3_num  <= r_s2_num;
            r_s3_sq32 <= n_s3_rnd[63:16];
            // accumulate history, saturate
            r_s4_w    <= r_s3_w;
            r_s4_neg  <= r_s3_neg;
            r_s4_num  <= r_s3_num;
            r_s4_hsat <= n_s4_sum[H_W];
            r_s4_h    <= n_s4_sum[H_W] ? H_MAX : n_s4_sum[H_W-1:0];
            // rounded dividend and doubled root divisor
            r_s6_dvd  <= sq_side_out.num + {{(NUM_W-ROOT_W){1'b0}}, sq_root};
            r_s6_dvs  <= {sq_root, 1'b0};
            r_s6_side <= dv_side_in;
        end
    end

    assign sq_side_in.weight = r_s4_w;
    assign sq_side_in.neg    = r_s4_neg;
    assign sq_side_in.num    = r_s4_num;
    assign sq_side_in.hist   = r_s4_h;
    assign sq_side_in.hsat   = r_s4_hsat;

    adgr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s4_vld),
        .i_rad   (sq_rad),
        .i_side  (sq_side_in),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side_out)
    );

    assign dv_side_in.weight = sq_side_out.weight;
    assign dv_side_in.neg    = sq_side_out.neg;
    assign dv_side_in.hist   = sq_side_out.hist;
    assign dv_side_in.hsat   = sq_side_out.hsat;

    adgr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s6_vld),
        .i_dvd   (r_s6_dvd),
        .i_dvs   (r_s6_dvs),
        .i_side  (r_s6_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Apply the signed step and clamp to the weight range
    always_comb begin
        w_ext  = WIDE_W'($signed(dv_side.weight));
        m_ext  = $signed({2'b00, dv_quo});
        w_wide = dv_side.neg ? (w_ext + m_ext) : (w_ext - m_ext);
        priority if (w_wide > W_HI) begin
            n_out_w    = W_HI[W_W-1:0];
            n_out_wsat = 1'b1;
        end else if (w_wide < W_LO) begin
            n_out_w    = W_LO[W_W-1:0];
            n_out_wsat = 1'b1;
        end else begin
            n_out_w    = w_wide[W_W-1:0];
            n_out_wsat = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_w   <= n_out_w;
            r_out_h   <= dv_side.hist;
            r_out_sat <= dv_side.hsat | n_out_wsat;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_weight_out = r_out_w;
    assign o_hist_out   = r_out_h;
    assign o_sat_flag   = r_out_sat;

endmodule

/* src/adgr_sqrt.sv */
// ---------------------------------------------------------------------------
// adgr_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ---------------------------------------------------------------------------
module adgr_sqrt import adgr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_sqrt_side        i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_sqrt_side        o_side
);

    localparam int REM_W = ROOT_W + 3;

    logic              r_vld  [SQ_STAGES];
    logic [REM_W-1:0]  r_rem  [SQ_STAGES];
    logic [ROOT_W-1:0] r_root [SQ_STAGES];
    logic [RAD_W-1:0]  r_rad  [SQ_STAGES];
    t_sqrt_side        r_side [SQ_STAGES];

    logic              n_vld  [SQ_STAGES];
    logic [REM_W-1:0]  n_rem  [SQ_STAGES];
    logic [ROOT_W-1:0] n_root [SQ_STAGES];
    logic [RAD_W-1:0]  n_rad  [SQ_STAGES];
    t_sqrt_side        n_side [SQ_STAGES];

    // Resolve one root bit per stage from the previous stage's remainder
    always_comb begin
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [RAD_W-1:0]  p_rad;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (k == 0) begin
                p_rem     = '0;
                p_root    = '0;
                p_rad     = i_rad;
                n_vld[k]  = i_vld;
                n_side[k] = i_side;
            end else begin
                p_rem     = r_rem[k-1];
                p_root    = r_root[k-1];
                p_rad     = r_rad[k-1];
                n_vld[k]  = r_vld[k-1];
                n_side[k] = r_side[k-1];
            end
            cur   = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
            trial = {1'b0, p_root, 2'b01};
            if (cur >= trial) begin
                n_rem[k]  = cur - trial;
                n_root[k] = {p_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur;
                n_root[k] = {p_root[ROOT_W-2:0], 1'b0};
            end
            n_rad[k] = {p_rad[RAD_W-3:0], 2'b00};
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_root = r_root[SQ_STAGES-1];
    assign o_side = r_side[SQ_STAGES-1];

endmodule

/* src/adgr_div.sv */
// ---------------------------------------------------------------------------
// adgr_div
// Pipelined restoring divider, one quotient bit resolved per stage.
// ---------------------------------------------------------------------------
module adgr_div import adgr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    input  t_div_side        i_side,
    output logic             o_vld,
    output logic [QUO_W-1:0] o_quo,
    output t_div_side        o_side
);

    localparam int HI_W = NUM_W - QUO_W;   // leading bits, always below the divisor

    logic             r_vld  [DIV_STAGES];
    logic [DVS_W-1:0] r_rem  [DIV_STAGES];
    logic [DVS_W-1:0] r_dvs  [DIV_STAGES];
    logic [QUO_W-1:0] r_bits [DIV_STAGES];
    t_div_side        r_side [DIV_STAGES];

    logic             n_vld  [DIV_STAGES];
    logic [DVS_W-1:0] n_rem  [DIV_STAGES];
    logic [DVS_W-1:0] n_dvs  [DIV_STAGES];
    logic [QUO_W-1:0] n_bits [DIV_STAGES];
    t_div_side        n_side [DIV_STAGES];

    // Shift in one dividend bit, subtract the divisor where it fits
    always_comb begin
        logic [DVS_W-1:0] p_rem;
        logic [QUO_W-1:0] p_bits;
        logic [DVS_W:0]   cur;
        logic             fit;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                p_rem     = {{(DVS_W-HI_W){1'b0}}, i_dvd[NUM_W-1 -: HI_W]};
                p_bits    = i_dvd[QUO_W-1:0];
                n_dvs[k]  = i_dvs;
                n_vld[k]  = i_vld;
                n_side[k] = i_side;
            end else begin
                p_rem     = r_rem[k-1];
                p_bits    = r_bits[k-1];
                n_dvs[k]  = r_dvs[k-1];
                n_vld[k]  = r_vld[k-1];
                n_side[k] = r_side[k-1];
            end
            cur = {p_rem, p_bits[QUO_W-1]};
            fit = (cur >= {1'b0, n_dvs[k]});
            if (fit) begin
                n_rem[k] = DVS_W'(cur - {1'b0, n_dvs[k]});
            end else begin
                n_rem[k] = cur[DVS_W-1:0];
            end
            n_bits[k] = {p_bits[QUO_W-2:0], fit};
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_dvs[k]  <= n_dvs[k];
                r_bits[k] <= n_bits[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_quo  = r_bits[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

endmodule

/* src/adgr_checker.sv */
// ---------------------------------------------------------------------------
// adgr_checker
// Port-level checks of the AdaGrad update block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adgr_checker import adgr_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [LR_W-1:0]       i_cfg_learn_rate,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic signed [W_W-1:0] i_weight_in,
    input logic signed [W_W-1:0] i_grad_in,
    input logic [H_W-1:0]        i_hist_in,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic signed [W_W-1:0] o_weight_out,
    input logic [H_W-1:0]        o_hist_out,
    input logic                  o_sat_flag
);

    // Input side stalls exactly when a result is held back
    `ADGR_ASSERT(a_stall_follows_out, i_clk, i_rst_n, o_stall == (o_valid && i_stall))

    // Saturation only shows with a clamped weight or a full history
    `ADGR_ASSERT(a_sat_cause, i_clk, i_rst_n, (o_valid && o_sat_flag) |-> (o_hist_out == H_MAX || o_weight_out == 32'sh7FFFFFFF || o_weight_out == 32'sh80000000))

    // Reset empties the pipeline
    `ADGR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

    // A held result stays put
    `ADGR_ASSERT(a_hold_result, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_weight_out) && $stable(o_hist_out)))

endmodule

bind adagrad_weight_update adgr_checker u_adgr_checker (.*);
